### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the balance table design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define BTT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define BTT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### design/btt_pkg.sv
// ----------------------------------------------------------------------------
// Balance table package
// Shared constants and types for the balance transfer table.
// ----------------------------------------------------------------------------
`default_nettype none

package btt_pkg;

  localparam int ACCOUNT_COUNT_DEF = 65536;
  localparam int IDX_W             = 16;
  localparam int AMT_W             = 32;
  localparam int BAL_W             = 64;

  localparam logic [BAL_W-1:0] START_BALANCE = 64'd1000000;

  // item kinds
  localparam logic KIND_XFER = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic             applied;
    logic [BAL_W-1:0] first_balance;
    logic [BAL_W-1:0] second_balance;
  } btt_result_t;

endpackage

`default_nettype wire

### design/btt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports, registered read data (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module btt_ram #(
  parameter  int WIDTH = 64,
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    ra_addr,
  output logic      [WIDTH-1:0] ra_data,
  input  wire logic [AW-1:0]    rb_addr,
  output logic      [WIDTH-1:0] rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

`default_nettype wire

### design/btt_ctrl.sv
// ----------------------------------------------------------------------------
// Balance table control
// Clearing pass, item capture, read-modify-write of the balance memory.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module btt_ctrl #(
  parameter int ACCOUNT_COUNT = btt_pkg::ACCOUNT_COUNT_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_kind,
  input  wire logic [btt_pkg::IDX_W-1:0] in_sender,
  input  wire logic [btt_pkg::IDX_W-1:0] in_receiver,
  input  wire logic [btt_pkg::AMT_W-1:0] in_amount,
  input  wire logic                      room,
  output logic                           res_push,
  output btt_pkg::btt_result_t           res
);

  import btt_pkg::*;

  localparam int AW = $clog2(ACCOUNT_COUNT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(ACCOUNT_COUNT - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [AW-1:0]    clr_cnt_r, clr_cnt_nxt;

  // captured item
  logic             kind_r;
  logic [IDX_W-1:0] snd_r, rcv_r;
  logic [AMT_W-1:0] amt_r;
  logic             snd_ok_r, rcv_ok_r;

  // receiver write-back pending for the cycle after execute
  logic             wb_pend_r, wb_pend_nxt;
  logic [AW-1:0]    wb_addr_r, wb_addr_nxt;
  logic [BAL_W-1:0] wb_data_r, wb_data_nxt;

  // write done in the previous cycle, not yet visible on the read ports
  logic             fwd_r, fwd_nxt;
  logic [AW-1:0]    fwd_addr_r, fwd_addr_nxt;
  logic [BAL_W-1:0] fwd_data_r, fwd_data_nxt;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [BAL_W-1:0] wdata;
  logic [BAL_W-1:0] ra_data, rb_data;

  logic             accept;
  logic [BAL_W-1:0] sb, rb;
  logic [BAL_W:0]   diff;
  logic [BAL_W-1:0] new_r;
  logic             ok, mv;

  btt_ram #(
    .WIDTH (BAL_W),
    .DEPTH (ACCOUNT_COUNT)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .ra_addr (AW'(in_sender)),
    .ra_data (ra_data),
    .rb_addr (AW'(in_receiver)),
    .rb_data (rb_data)
  );

  assign in_ready = (state_r == S_IDLE) && room;
  assign accept   = in_valid && in_ready;

  // balances with forwarding of last cycle's write
  assign sb = (fwd_r && (fwd_addr_r == AW'(snd_r))) ? fwd_data_r : ra_data;
  assign rb = (fwd_r && (fwd_addr_r == AW'(rcv_r))) ? fwd_data_r : rb_data;

  // borrow out of the debit doubles as the funds check
  assign diff  = {1'b0, sb} - {{(BAL_W - AMT_W + 1){1'b0}}, amt_r};
  assign new_r = rb + {{(BAL_W - AMT_W){1'b0}}, amt_r};
  assign ok    = (kind_r == KIND_XFER) && snd_ok_r && rcv_ok_r && !diff[BAL_W];
  assign mv    = ok && (snd_r != rcv_r);

  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    wb_pend_nxt  = wb_pend_r;
    wb_addr_nxt  = wb_addr_r;
    wb_data_nxt  = wb_data_r;
    fwd_nxt      = 1'b0;
    fwd_addr_nxt = fwd_addr_r;
    fwd_data_nxt = fwd_data_r;
    we           = 1'b0;
    waddr        = wb_addr_r;
    wdata        = wb_data_r;
    res_push     = 1'b0;
    res          = '0;

    unique case (state_r)
      S_CLEAR: begin
        we          = 1'b1;
        waddr       = clr_cnt_r;
        wdata       = START_BALANCE;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (wb_pend_r) begin
          we           = 1'b1;
          wb_pend_nxt  = 1'b0;
          fwd_nxt      = 1'b1;
          fwd_addr_nxt = wb_addr_r;
          fwd_data_nxt = wb_data_r;
        end
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_push = 1'b1;
        if (kind_r == KIND_READ) begin
          res.applied       = 1'b0;
          res.first_balance = snd_ok_r ? sb : '0;
        end else begin
          res.applied        = ok;
          res.first_balance  = !snd_ok_r ? '0 : (mv ? diff[BAL_W-1:0] : sb);
          res.second_balance = !rcv_ok_r ? '0 : (mv ? new_r : rb);
        end
        // debit now, credit next cycle
        we          = mv;
        waddr       = AW'(snd_r);
        wdata       = diff[BAL_W-1:0];
        wb_pend_nxt = mv;
        wb_addr_nxt = AW'(rcv_r);
        wb_data_nxt = new_r;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      wb_pend_r <= 1'b0;
      fwd_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      wb_pend_r <= wb_pend_nxt;
      fwd_r     <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr_r  <= wb_addr_nxt;
    wb_data_r  <= wb_data_nxt;
    fwd_addr_r <= fwd_addr_nxt;
    fwd_data_r <= fwd_data_nxt;
    if (accept) begin
      kind_r   <= in_kind;
      snd_r    <= in_sender;
      rcv_r    <= in_receiver;
      amt_r    <= in_amount;
      snd_ok_r <= 32'(in_sender) < 32'(ACCOUNT_COUNT);
      rcv_ok_r <= 32'(in_receiver) < 32'(ACCOUNT_COUNT);
    end
  end

  `BTT_ASSERT_NXT(a_exec_one_cycle, clk, rst_n, state_r == S_EXEC, state_r == S_IDLE)
  `BTT_ASSERT_IMP(a_no_accept_clear, clk, rst_n, state_r == S_CLEAR, !in_ready)
  `BTT_ASSERT_IMP(a_no_pend_in_exec, clk, rst_n, state_r == S_EXEC, !wb_pend_r)
  `BTT_ASSERT_NXT(a_accept_to_exec, clk, rst_n, accept, state_r == S_EXEC)

endmodule

`default_nettype wire

### design/btt_out_q.sv
// ----------------------------------------------------------------------------
// Result queue
// Output register plus one skid entry between execute and the result port.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module btt_out_q (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire btt_pkg::btt_result_t push_data,
  output logic                      room,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output btt_pkg::btt_result_t      out_data
);

  import btt_pkg::*;

  logic        out_valid_r, sk_valid_r;
  btt_result_t out_data_r, sk_data_r;
  logic        pop;

  assign pop       = out_valid_r && out_ready;
  assign room      = !sk_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else begin
      if (pop) begin
        if (sk_valid_r) begin
          out_valid_r <= 1'b1;
          sk_valid_r  <= push;
        end else begin
          out_valid_r <= push;
        end
      end else if (!out_valid_r) begin
        out_valid_r <= push;
      end else if (push) begin
        sk_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (sk_valid_r) begin
        out_data_r <= sk_data_r;
        sk_data_r  <= push_data;
      end else begin
        out_data_r <= push_data;
      end
    end else if (!out_valid_r) begin
      out_data_r <= push_data;
    end else if (push) begin
      sk_data_r <= push_data;
    end
  end

  `BTT_ASSERT_IMP(a_skid_behind_head, clk, rst_n, sk_valid_r, out_valid_r)
  `BTT_ASSERT_IMP(a_no_overflow, clk, rst_n, sk_valid_r && !pop, !push)

endmodule

`default_nettype wire

### design/balance_transfer_table_unit.sv
// ----------------------------------------------------------------------------
// Balance transfer table unit
// Table of 64-bit account balances with conditional transfers and reads.
// ----------------------------------------------------------------------------
// After reset the unit runs a clearing pass that writes the start balance of
// 1000000 into every one of the ACCOUNT_COUNT memory entries, one entry per
// cycle; in_tready stays low for the whole pass. For each item, in the accept
// cycle both addresses go to the two read ports of the balance memory, in the
// next cycle the funds check, debit and credit are worked out and the result
// is queued. The memory has a single write port, so the sender is written in
// the execute cycle and the receiver in the following cycle, which overlaps
// the accept of the next item; a forwarding register covers a read of the
// entry being written. A new item is accepted only after the previous one
// has left execute. A two-entry result queue (output register plus skid)
// lets the next item enter while a result waits.
// Transfers debit the sender and credit the receiver only when the sender
// holds at least the amount; the credit wraps at 64 bits. Indices at or
// above ACCOUNT_COUNT refuse the transfer and report a balance of zero.
// ----------------------------------------------------------------------------
`default_nettype none

module balance_transfer_table_unit #(
  parameter int ACCOUNT_COUNT = btt_pkg::ACCOUNT_COUNT_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [63:0]  in_tdata,   // sender[15:0], receiver[31:16], amount[63:32]
  input  wire logic         in_tuser,   // kind: 0 transfer, 1 read
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [127:0] out_tdata,  // first_balance[63:0], second_balance[127:64]
  output logic              out_tuser   // applied
);

  import btt_pkg::*;

  logic        room;
  logic        res_push;
  btt_result_t res;
  btt_result_t out_res;

  btt_ctrl #(
    .ACCOUNT_COUNT (ACCOUNT_COUNT)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_kind     (in_tuser),
    .in_sender   (in_tdata[15:0]),
    .in_receiver (in_tdata[31:16]),
    .in_amount   (in_tdata[63:32]),
    .room        (room),
    .res_push    (res_push),
    .res         (res)
  );

  btt_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {out_res.second_balance, out_res.first_balance};
  assign out_tuser = out_res.applied;

endmodule

`default_nettype wire
